>>> sv/vsdt_pkg.sv
// shared types and constants for the vertex snap dedup table
package vsdt_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned CoordBitsDef  = 24;
  localparam int unsigned TolBits       = 52;
  localparam int unsigned CellStages    = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

>>> sv/vsdt_ram.sv
// generic simple dual port ram with registered read
module vsdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/vsdt_cell.sv
// one axis cell: squared difference added to the partial sum from the previous cell
module vsdt_cell #(
  parameter int unsigned CoordBits = 24,
  parameter int unsigned SumBits   = 52,
  parameter int unsigned IdxBits   = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [CoordBits-1:0] point_i,
  input  logic signed [CoordBits-1:0] stored_i,
  input  logic [SumBits-1:0]          psum_i,
  input  vsdt_pkg::tag_t              tag_i,
  input  logic [IdxBits-1:0]          idx_i,
  output logic [SumBits-1:0]          psum_o,
  output vsdt_pkg::tag_t              tag_o,
  output logic [IdxBits-1:0]          idx_o
);

  localparam int unsigned MagBits = CoordBits + 1;

  logic signed [CoordBits:0] diff;
  logic [MagBits-1:0]        mag_d, mag_q;
  logic [2*MagBits-1:0]      sq_q;
  logic [SumBits-1:0]        psum_a_q, psum_b_q, sum_q;
  vsdt_pkg::tag_t            tag_a_q, tag_b_q, tag_c_q;
  logic [IdxBits-1:0]        idx_a_q, idx_b_q, idx_c_q;

  always_comb begin
    diff  = (CoordBits+1)'(point_i) - (CoordBits+1)'(stored_i);
    mag_d = diff[CoordBits] ? MagBits'(-diff) : MagBits'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    psum_a_q <= psum_i;
    idx_a_q  <= idx_i;
    sq_q     <= mag_q * mag_q;
    psum_b_q <= psum_a_q;
    idx_b_q  <= idx_a_q;
    sum_q    <= psum_b_q + SumBits'(sq_q);
    idx_c_q  <= idx_b_q;
  end

  assign psum_o = sum_q;
  assign tag_o  = tag_c_q;
  assign idx_o  = idx_c_q;

endmodule

>>> sv/vertex_snap_dedup_table.sv
// vertex snap dedup table: nearest stored point search with tolerance snap and append
// one item at a time; the table is scanned one entry a cycle through the ram read port, and
// each entry then passes a chain of three axis cells of three stages before the nearest is
// kept; an empty table skips the scan and goes straight to the decision
// the next word can be taken in the same cycle that the result shows; a stalled result delays the next decision
// asynchronous active-low reset empties the table, clears the duplicate flag and the tolerance
module vertex_snap_dedup_table #(
  parameter int unsigned TableDepth = vsdt_pkg::TableDepthDef,
  parameter int unsigned CoordBits  = vsdt_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vsdt_pkg::TolBits-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [CoordBits-1:0]       coord_x_i,
  input  logic signed [CoordBits-1:0]       coord_y_i,
  input  logic signed [CoordBits-1:0]       coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [$clog2(TableDepth)-1:0]     match_index_o,
  output logic                              is_new_o,
  output logic                              table_full_o,
  output logic                              dup_seen_o
);

  localparam int unsigned IdxBits = $clog2(TableDepth);
  localparam int unsigned CntBits = $clog2(TableDepth + 1);
  localparam int unsigned SumBits = 2 * CoordBits + 4;
  localparam int unsigned CmpBits = (SumBits > vsdt_pkg::TolBits) ? SumBits
                                                                  : vsdt_pkg::TolBits;
  localparam int unsigned Stg     = vsdt_pkg::CellStages;

  vsdt_pkg::state_e state_q, state_d;

  logic [vsdt_pkg::TolBits-1:0] tol_q;
  logic [CntBits-1:0]           count_q, count_d;
  logic                         dup_q, dup_d;
  logic [IdxBits-1:0]           addr_q, addr_d;
  logic signed [CoordBits-1:0]  px_q, py_q, pz_q;
  vsdt_pkg::tag_t               issue_tag_q, issue_tag_d;
  logic [IdxBits-1:0]           issue_idx_q;

  logic                         best_valid_q, best_valid_d;
  logic [SumBits-1:0]           best_d_q, best_d_d;
  logic [IdxBits-1:0]           best_idx_q, best_idx_d;

  logic                         out_valid_q, out_valid_d;
  logic [IdxBits-1:0]           res_idx_q, res_idx_d;
  logic                         res_new_q, res_new_d;
  logic                         res_full_q, res_full_d;
  logic                         res_dup_q, res_dup_d;

  logic                         accept, wr_en, last_addr;
  logic [3*CoordBits-1:0]       rdata;
  logic signed [CoordBits-1:0]  sy_dly_q [Stg];
  logic signed [CoordBits-1:0]  sz_dly_q [2*Stg];

  logic [SumBits-1:0]           psum0, psum1, psum2;
  vsdt_pkg::tag_t               tag0, tag1, tag2;
  logic [IdxBits-1:0]           idx0, idx1, idx2;

  assign in_stall_o = (state_q != vsdt_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign last_addr  = (CntBits'(addr_q) + CntBits'(1)) == count_q;

  vsdt_ram #(
    .Width(3 * CoordBits),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[IdxBits-1:0]),
    .wdata_i({pz_q, py_q, px_q}),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    sy_dly_q[0] <= rdata[2*CoordBits-1:CoordBits];
    sz_dly_q[0] <= rdata[3*CoordBits-1:2*CoordBits];
    for (int i = 1; i < Stg; i++) begin
      sy_dly_q[i] <= sy_dly_q[i-1];
    end
    for (int i = 1; i < 2*Stg; i++) begin
      sz_dly_q[i] <= sz_dly_q[i-1];
    end
  end

  vsdt_cell #(.CoordBits(CoordBits), .SumBits(SumBits), .IdxBits(IdxBits)) u_cell_x (
    .clk_i, .rst_ni,
    .point_i(px_q), .stored_i(rdata[CoordBits-1:0]), .psum_i('0),
    .tag_i(issue_tag_q), .idx_i(issue_idx_q),
    .psum_o(psum0), .tag_o(tag0), .idx_o(idx0)
  );

  vsdt_cell #(.CoordBits(CoordBits), .SumBits(SumBits), .IdxBits(IdxBits)) u_cell_y (
    .clk_i, .rst_ni,
    .point_i(py_q), .stored_i(sy_dly_q[Stg-1]), .psum_i(psum0),
    .tag_i(tag0), .idx_i(idx0),
    .psum_o(psum1), .tag_o(tag1), .idx_o(idx1)
  );

  vsdt_cell #(.CoordBits(CoordBits), .SumBits(SumBits), .IdxBits(IdxBits)) u_cell_z (
    .clk_i, .rst_ni,
    .point_i(pz_q), .stored_i(sz_dly_q[2*Stg-1]), .psum_i(psum1),
    .tag_i(tag1), .idx_i(idx1),
    .psum_o(psum2), .tag_o(tag2), .idx_o(idx2)
  );

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    issue_tag_d  = '0;
    best_valid_d = best_valid_q;
    best_d_d     = best_d_q;
    best_idx_d   = best_idx_q;
    count_d      = count_q;
    dup_d        = dup_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_idx_d    = res_idx_q;
    res_new_d    = res_new_q;
    res_full_d   = res_full_q;
    res_dup_d    = res_dup_q;
    wr_en        = 1'b0;

    if (tag2.valid && (!best_valid_q || psum2 < best_d_q)) begin
      best_valid_d = 1'b1;
      best_d_d     = psum2;
      best_idx_d   = idx2;
    end

    case (state_q)
      vsdt_pkg::ST_IDLE: begin
        if (accept) begin
          addr_d       = '0;
          best_valid_d = 1'b0;
          state_d      = (count_q == '0) ? vsdt_pkg::ST_DECIDE : vsdt_pkg::ST_SCAN;
        end
      end
      vsdt_pkg::ST_SCAN: begin
        issue_tag_d.valid = 1'b1;
        issue_tag_d.last  = last_addr;
        addr_d            = addr_q + IdxBits'(1);
        if (last_addr) begin
          state_d = vsdt_pkg::ST_DRAIN;
        end
      end
      vsdt_pkg::ST_DRAIN: begin
        if (tag2.valid && tag2.last) begin
          state_d = vsdt_pkg::ST_DECIDE;
        end
      end
      vsdt_pkg::ST_DECIDE: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          state_d     = vsdt_pkg::ST_IDLE;
          if (best_valid_q && (CmpBits'(best_d_q) <= CmpBits'(tol_q))) begin
            dup_d      = 1'b1;
            res_idx_d  = best_idx_q;
            res_new_d  = 1'b0;
            res_full_d = 1'b0;
            res_dup_d  = 1'b1;
          end else if (count_q == CntBits'(TableDepth)) begin
            res_idx_d  = '0;
            res_new_d  = 1'b0;
            res_full_d = 1'b1;
            res_dup_d  = dup_q;
          end else begin
            wr_en      = 1'b1;
            count_d    = count_q + CntBits'(1);
            res_idx_d  = count_q[IdxBits-1:0];
            res_new_d  = 1'b1;
            res_full_d = 1'b0;
            res_dup_d  = dup_q;
          end
        end
      end
      default: state_d = vsdt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= vsdt_pkg::ST_IDLE;
      tol_q        <= '0;
      count_q      <= '0;
      dup_q        <= 1'b0;
      addr_q       <= '0;
      issue_tag_q  <= '0;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
      count_q      <= count_d;
      dup_q        <= dup_d;
      addr_q       <= addr_d;
      issue_tag_q  <= issue_tag_d;
      best_valid_q <= best_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      pz_q <= coord_z_i;
    end
    issue_idx_q <= addr_q;
    best_d_q    <= best_d_d;
    best_idx_q  <= best_idx_d;
    res_idx_q   <= res_idx_d;
    res_new_q   <= res_new_d;
    res_full_q  <= res_full_d;
    res_dup_q   <= res_dup_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_index_o = res_idx_q;
  assign is_new_o      = res_new_q;
  assign table_full_o  = res_full_q;
  assign dup_seen_o    = res_dup_q;

endmodule

>>> sv/vsdt_checker.sv
// port level checks for the vertex snap dedup table
module vsdt_checker #(
  parameter int unsigned IdxBits = 10
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [IdxBits-1:0] match_index_o,
  input logic               is_new_o,
  input logic               table_full_o,
  input logic               dup_seen_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(match_index_o))
    else $error("stalled output word changed");

  a_new_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && table_full_o))
    else $error("word both appended and full");

  a_full_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> match_index_o == '0)
    else $error("full word carries nonzero index");

  a_snap_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_new_o && !table_full_o |-> dup_seen_o)
    else $error("snapped word without duplicate flag");

  a_dup_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dup_seen_o |=> dup_seen_o)
    else $error("duplicate flag dropped");

endmodule

bind vertex_snap_dedup_table vsdt_checker #(.IdxBits($clog2(TableDepth))) u_vsdt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .match_index_o(match_index_o),
  .is_new_o     (is_new_o),
  .table_full_o (table_full_o),
  .dup_seen_o   (dup_seen_o)
);
